@@ rtl/core/vertex_weld_table_assert.svh @@
// Assertion macros for the vertex weld table.
// The macros expect signals named clk and rst in the including module.
`ifndef VERTEX_WELD_TABLE_ASSERT_SVH
`define VERTEX_WELD_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside of reset.
`define VWT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The expression must never be true outside of reset.
`define VWT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VWT_ASSERT(label, prop, msg)
`define VWT_ASSERT_NEVER(label, expr, msg)
`endif

`endif

@@ rtl/core/vwt_pkg.sv @@
// Shared types, sizes and the per-axis compare function of the vertex weld table.
// Used by the interfaces, the compare cells, the register block and the top level.
`timescale 1ns / 1ps

package vwt_pkg;

  localparam int NUM_CELLS = 1024;
  localparam int COORD_W   = 32;
  localparam int TOL_W     = 31;
  localparam int AXES_W    = 2;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = TOL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL_X    = 2'd0,
    CFG_TOL_Y    = 2'd1,
    CFG_TOL_Z    = 2'd2,
    CFG_NUM_AXES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Control part of an item as it walks down the chain.
  typedef struct packed {
    logic             valid;
    logic             clear;
    logic             done;
    logic             is_new;
    logic [IDX_W-1:0] index;
  } token_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol_x;
    logic [TOL_W-1:0] tol_y;
    logic [TOL_W-1:0] tol_z;
    logic             use_y;
    logic             use_z;
  } cfg_t;

  // True when |a - b| <= tol, computed one bit wider so it cannot wrap.
  function automatic logic axis_close(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
    return mag <= {{(COORD_W + 1 - TOL_W){1'b0}}, tol};
  endfunction

endpackage

@@ rtl/core/vwt_point_if.sv @@
// Input channel of the vertex weld table: one mesh corner point per item.
// Depends on vwt_pkg for the coordinate width.
`timescale 1ns / 1ps

interface vwt_point_if;
  import vwt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic                      clear_table;

  modport source (output valid, coord_x, coord_y, coord_z, clear_table, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, clear_table, output ready);
endinterface

@@ rtl/core/vwt_result_if.sv @@
// Output channel of the vertex weld table: one vertex index per item.
// Depends on vwt_pkg for the index width.
`timescale 1ns / 1ps

interface vwt_result_if;
  import vwt_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] vertex_index;
  logic             is_new;
  logic             table_full;

  modport source (output valid, vertex_index, is_new, table_full, input ready);
  modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface

@@ rtl/core/vwt_cfg.sv @@
// Configuration registers of the vertex weld table: tolerances and axis count.
// Depends on vwt_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module vwt_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  vwt_pkg::cfg_reg_t              cfg_index,
  input  logic [vwt_pkg::CFG_W-1:0]      cfg_data,
  output vwt_pkg::cfg_t                  cfg
);
  import vwt_pkg::*;

  logic [TOL_W-1:0]  tol_x;
  logic [TOL_W-1:0]  tol_y;
  logic [TOL_W-1:0]  tol_z;
  logic [AXES_W-1:0] num_axes;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_x    <= '0;
      tol_y    <= '0;
      tol_z    <= '0;
      num_axes <= AXES_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOL_X:    tol_x    <= cfg_data[TOL_W-1:0];
        CFG_TOL_Y:    tol_y    <= cfg_data[TOL_W-1:0];
        CFG_TOL_Z:    tol_z    <= cfg_data[TOL_W-1:0];
        CFG_NUM_AXES: num_axes <= cfg_data[AXES_W-1:0];
        default:      ;
      endcase
    end
  end

  // An axis count of zero compares the first axis only, like a count of one.
  always_comb begin
    cfg.tol_x = tol_x;
    cfg.tol_y = tol_y;
    cfg.tol_z = tol_z;
    cfg.use_y = (num_axes >= AXES_W'(2));
    cfg.use_z = (num_axes == AXES_W'(3));
  end

endmodule

@@ rtl/core/vwt_cell.sv @@
// One compare cell of the weld chain: holds one stored vertex and passes items on.
// Depends on vwt_pkg for the point, token and configuration types.
`timescale 1ns / 1ps

module vwt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  vwt_pkg::cfg_t             cfg,
  input  logic [vwt_pkg::IDX_W-1:0] cell_index,
  input  vwt_pkg::point_t           pt_in,
  input  vwt_pkg::token_t           tok_in,
  output vwt_pkg::point_t           pt_out,
  output vwt_pkg::token_t           tok_out,
  output logic                      occupied
);
  import vwt_pkg::*;

  point_t stored;
  token_t tok_next;
  logic   occupied_next;
  logic   live;
  logic   searching;
  logic   close;
  logic   hit;
  logic   take;

  always_comb begin
    // A passing clear item empties this cell before it is compared.
    live      = occupied && !(tok_in.valid && tok_in.clear);
    searching = tok_in.valid && !tok_in.done;
    close     = axis_close(pt_in.x, stored.x, cfg.tol_x) &&
                (!cfg.use_y || axis_close(pt_in.y, stored.y, cfg.tol_y)) &&
                (!cfg.use_z || axis_close(pt_in.z, stored.z, cfg.tol_z));
    hit       = searching && live && close;
    // Occupied cells form a prefix, so the first empty cell is the next free slot.
    take      = searching && !live;

    tok_next = tok_in;
    if (hit || take) begin
      tok_next.done  = 1'b1;
      tok_next.index = cell_index;
    end
    if (take) begin
      tok_next.is_new = 1'b1;
    end
    occupied_next = take || live;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      occupied      <= 1'b0;
    end else if (adv) begin
      tok_out  <= tok_next;
      occupied <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_out <= pt_in;
      if (take) begin
        stored <= pt_in;
      end
    end
  end

endmodule

@@ rtl/core/vertex_weld_table.sv @@
// Top level of the vertex weld table: register block and a chain of compare cells.
// Depends on vwt_pkg, vwt_point_if, vwt_result_if, vwt_cfg, vwt_cell and the assert header.
`timescale 1ns / 1ps
//
// Usage:
// Points arrive on the point channel, one item per accepted valid/ready handshake,
// with signed Q16.16 coordinates and a clear_table flag. Each item walks down a chain
// of 1024 compare cells, one cell per cycle while the chain moves; cell k holds stored
// vertex k. An item takes the index of the first cell that matches within the tolerances,
// or fills the first empty cell and reports is_new. If every cell is occupied and none
// matches, the result reports table_full with index 0.
// A new item can enter in every cycle that the chain advances, so the sustained rate is
// one item per cycle while the receiver does not stall; the chain length sets the latency.
// The last cell's register is the output register. When the receiver stalls, the whole
// chain holds and point.ready drops until the waiting result is taken.
// Reset empties the table, sets all tolerances to zero and compares three axes.
// Tolerances and the axis count are written on cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
`include "vertex_weld_table_assert.svh"

module vertex_weld_table (
  input  logic                          clk,
  input  logic                          rst,
  vwt_point_if.sink                     point,
  vwt_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [vwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vwt_pkg::CFG_W-1:0]     cfg_data
);
  import vwt_pkg::*;

  cfg_t   cfg;
  logic   adv;
  logic   clear_in;
  point_t pt_chain [NUM_CELLS+1];
  token_t tok_chain [NUM_CELLS+1];
  logic   cell_vld [NUM_CELLS];

  vwt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The chain moves whenever the output register is empty or being taken.
  assign adv         = !tok_chain[NUM_CELLS].valid || result.ready;
  assign point.ready = adv;

  assign pt_chain[0]  = {point.coord_x, point.coord_y, point.coord_z};
  assign tok_chain[0] = {point.valid, point.clear_table, 1'b0, 1'b0, {IDX_W{1'b0}}};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    vwt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cfg        (cfg),
      .cell_index (IDX_W'(k)),
      .pt_in      (pt_chain[k]),
      .tok_in     (tok_chain[k]),
      .pt_out     (pt_chain[k+1]),
      .tok_out    (tok_chain[k+1]),
      .occupied   (cell_vld[k])
    );
  end

  // An item that reaches the end without a match or a free cell found the table full.
  assign result.valid        = tok_chain[NUM_CELLS].valid;
  assign result.vertex_index = tok_chain[NUM_CELLS].index;
  assign result.is_new       = tok_chain[NUM_CELLS].is_new;
  assign result.table_full   = !tok_chain[NUM_CELLS].done;

  assign clear_in = point.valid && point.ready && point.clear_table;

  `VWT_ASSERT(a_clear_fills_first, clear_in |=> cell_vld[0], "cell 0 empty after clear")
  `VWT_ASSERT_NEVER(a_prefix_fill, cell_vld[1] && !cell_vld[0], "cell 1 filled before cell 0")
  `VWT_ASSERT(a_new_not_full, result.valid && result.is_new |-> !result.table_full, "new and full")

endmodule
